FILE: rtl/hkr_pkg.sv
package hkr_pkg;

    localparam int MAX_HELD_DEF    = 16;
    localparam int REPORT_KEYS_DEF = 6;
    localparam int SLOT_FIELDS     = 6;
    localparam int KEY_W           = 9;
    localparam int BYTE_W          = 8;
    localparam int KCNT_W          = 3;

    localparam logic ACT_PRESS   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic             cmp;
        logic             upd;
        logic             release_op;
        logic             any_hit;
        logic [KEY_W-1:0] code;
    } t_ctl;

endpackage

FILE: rtl/hid_keyboard_report_tracker.sv
// Keyboard report tracker: keeps the held keys in press order and builds a
// boot-keyboard style report for every key event.
//
// Input: drive i_action/i_scancode/i_modifiers with start high; the event is
// taken at a rising edge where start is high and busy is low.
// Output: one report per event, shown for exactly one cycle with o_valid high.
//
// Timing: an event passes through compare (every cell checks its key
// against the scancode) and then update (append into the first free
// cell, or shift the cells after the hit one place left). The report shows
// in the cycle after the update; busy is high during compare and update,
// so no new event is taken until the current one has left update.
// The compare/update pass over the row of cells sets this limit.
//
// Reset clears every cell's valid bit, the key count and the sequencer.
// The receiver cannot stall: a report is present for one cycle only.
module hid_keyboard_report_tracker
    import hkr_pkg::*;
#(
    parameter int MAX_HELD    = MAX_HELD_DEF,
    parameter int REPORT_KEYS = REPORT_KEYS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_action,
    input  logic [KEY_W-1:0]  i_scancode,
    input  logic [BYTE_W-1:0] i_modifiers,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_report_modifiers,
    output logic [KCNT_W-1:0] o_key_count,
    output logic [BYTE_W-1:0] o_key_0,
    output logic [BYTE_W-1:0] o_key_1,
    output logic [BYTE_W-1:0] o_key_2,
    output logic [BYTE_W-1:0] o_key_3,
    output logic [BYTE_W-1:0] o_key_4,
    output logic [BYTE_W-1:0] o_key_5,
    output logic              o_dropped_full
);

    localparam int CNT_W = $clog2(MAX_HELD + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic              r_action;
    logic [KEY_W-1:0]  r_code;
    logic [BYTE_W-1:0] r_mods;
    logic              r_valid;
    logic              r_drop;
    logic [CNT_W-1:0]  r_count;

    t_ctl              w_ctl;
    logic [KEY_W-1:0]  w_key   [MAX_HELD];
    logic              w_vld   [MAX_HELD];
    logic              w_hit   [MAX_HELD];
    logic              w_full;
    logic              w_any_hit;
    logic              w_accept;
    logic [KCNT_W-1:0] w_shown;
    logic [BYTE_W-1:0] w_slot  [SLOT_FIELDS];

    assign w_accept  = start && !busy;
    assign busy      = (r_state != ST_IDLE);
    assign w_any_hit = w_hit[MAX_HELD-1];
    assign w_full    = w_vld[MAX_HELD-1];

    assign w_ctl.cmp        = (r_state == ST_CMP);
    assign w_ctl.upd        = (r_state == ST_UPD);
    assign w_ctl.release_op = r_action;
    assign w_ctl.any_hit    = w_any_hit;
    assign w_ctl.code       = r_code;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_HELD; gi++) begin : g_cell
            logic             w_pv;
            logic             w_hin;
            logic [KEY_W-1:0] w_rk;
            logic             w_rv;
            if (gi == 0) begin : g_first
                assign w_pv  = 1'b1;
                assign w_hin = 1'b0;
            end else begin : g_mid
                assign w_pv  = w_vld[gi-1];
                assign w_hin = w_hit[gi-1];
            end
            if (gi == MAX_HELD - 1) begin : g_last
                assign w_rk = '0;
                assign w_rv = 1'b0;
            end else begin : g_inner
                assign w_rk = w_key[gi+1];
                assign w_rv = w_vld[gi+1];
            end
            hkr_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_prev_valid  (w_pv),
                .i_hit_in      (w_hin),
                .i_right_key   (w_rk),
                .i_right_valid (w_rv),
                .o_key         (w_key[gi]),
                .o_valid       (w_vld[gi]),
                .o_hit_out     (w_hit[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_CMP;
            ST_CMP:  n_state = ST_UPD;
            ST_UPD:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= w_ctl.upd;
            if (w_ctl.upd && !w_any_hit && r_action == ACT_PRESS && !w_full) begin
                r_count <= r_count + 1'b1;
            end else if (w_ctl.upd && w_any_hit && r_action == ACT_RELEASE) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_code   <= i_scancode;
            r_mods   <= i_modifiers;
        end
        if (w_ctl.upd) begin
            r_drop <= (r_action == ACT_PRESS) && !w_any_hit && w_full;
        end
    end

    assign w_shown = (r_count < CNT_W'(REPORT_KEYS)) ? KCNT_W'(r_count)
                                                    : KCNT_W'(REPORT_KEYS);

    generate
        for (gi = 0; gi < SLOT_FIELDS; gi++) begin : g_slot
            assign w_slot[gi] = (KCNT_W'(gi) < w_shown) ? w_key[gi][BYTE_W-1:0] : '0;
        end
    endgenerate

    assign o_valid            = r_valid;
    assign o_report_modifiers = r_mods;
    assign o_key_count        = w_shown;
    assign o_key_0            = w_slot[0];
    assign o_key_1            = w_slot[1];
    assign o_key_2            = w_slot[2];
    assign o_key_3            = w_slot[3];
    assign o_key_4            = w_slot[4];
    assign o_key_5            = w_slot[5];
    assign o_dropped_full     = r_drop;

endmodule

FILE: rtl/hkr_cell.sv
module hkr_cell
    import hkr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctl             i_ctl,
    input  logic             i_prev_valid,
    input  logic             i_hit_in,
    input  logic [KEY_W-1:0] i_right_key,
    input  logic             i_right_valid,
    output logic [KEY_W-1:0] o_key,
    output logic             o_valid,
    output logic             o_hit_out
);

    logic [KEY_W-1:0] r_key;
    logic             r_valid;
    logic             r_match;
    logic             w_first_empty;

    assign w_first_empty = !r_valid && i_prev_valid;
    assign o_key         = r_key;
    assign o_valid       = r_valid;
    assign o_hit_out     = i_hit_in || r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_match <= r_valid && (r_key == i_ctl.code);
        end else if (i_ctl.upd) begin
            if (i_ctl.release_op == ACT_RELEASE) begin
                // close the gap: every cell at or after the hit pulls from the right
                if (i_ctl.any_hit && o_hit_out) begin
                    r_valid <= i_right_valid;
                end
            end else if (!i_ctl.any_hit && w_first_empty) begin
                r_valid <= 1'b1;
            end
            r_match <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd) begin
            if (i_ctl.release_op == ACT_RELEASE) begin
                if (i_ctl.any_hit && o_hit_out) begin
                    r_key <= i_right_key;
                end
            end else if (!i_ctl.any_hit && w_first_empty) begin
                r_key <= i_ctl.code;
            end
        end
    end

endmodule

FILE: rtl/hkr_checker.sv
module hkr_checker
    import hkr_pkg::*;
#(
    parameter int REPORT_KEYS = REPORT_KEYS_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic [KCNT_W-1:0] o_key_count,
    input logic [BYTE_W-1:0] o_key_5,
    input logic              o_dropped_full
);

    // every report closes a transaction that held busy the cycle before
    a_report_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy) && !busy)
        else $error("report without a transaction in flight");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy ##1 busy ##1 o_valid)
        else $error("accepted transaction did not produce a report on time");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_key_count <= KCNT_W'(REPORT_KEYS)))
        else $error("key count above report slots");

    // a drop only happens with the table full, so all report slots are used
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped_full) |-> (o_key_count == KCNT_W'(REPORT_KEYS)))
        else $error("drop flagged while report not full");

    a_unused_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_key_count < KCNT_W'(SLOT_FIELDS)) |-> (o_key_5 == '0))
        else $error("unused last slot not zero");

endmodule

bind hid_keyboard_report_tracker hkr_checker #(
    .REPORT_KEYS (REPORT_KEYS)
) u_hkr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_key_count    (o_key_count),
    .o_key_5        (o_key_5),
    .o_dropped_full (o_dropped_full)
);
